// ===== rtl/lwsa_pkg.sv =====
// shared types and constants for the lattice walk self-avoid checker
`default_nettype none
package lwsa_pkg;

	// coordinate width on each lattice axis (two's complement, wraps)
	localparam int COORD_W = 7;

	// defaults for the top level parameters
	localparam int MAX_LENGTH_DEF = 64;
	localparam int MAX_DIM_DEF    = 128;

	// register file
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam logic REG_WALK_LENGTH = 1'b0;
	localparam logic REG_DIMENSIONS  = 1'b1;
	localparam logic [6:0] WALK_LENGTH_RST = 7'd30;
	localparam logic [7:0] DIMENSIONS_RST  = 8'd2;

	// control handed from the sequencer to the position register and the cells
	typedef struct packed {
		logic shift;   // push the new position into the chain
		logic restart; // walk finished, return to the origin
	} lwsa_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/lwsa_pos.sv =====
// current lattice position, one coordinate register per axis
`default_nettype none
module lwsa_pos #(
	parameter int MAX_DIM = lwsa_pkg::MAX_DIM_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire lwsa_pkg::lwsa_ctl_t                 ctl,
	input  wire logic                                step,
	input  wire logic [7:0]                          axis,
	input  wire logic                                up,
	output logic [MAX_DIM*lwsa_pkg::COORD_W-1:0]     pos
);
	import lwsa_pkg::*;

	logic [8:0] axis_c;

	// axis beyond the last one lands on the last one
	always_comb begin
		if ({1'b0, axis} >= 9'(MAX_DIM)) begin
			axis_c = 9'(MAX_DIM - 1);
		end else begin
			axis_c = {1'b0, axis};
		end
	end

	// one coordinate register per axis, plus or minus one on its step
	for (genvar i = 0; i < MAX_DIM; i++) begin : g_coord
		logic [COORD_W-1:0] coord_q;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				coord_q <= '0;
			end else if (ctl.restart) begin
				coord_q <= '0;
			end else if (step && (axis_c == 9'(i))) begin
				if (up) begin
					coord_q <= coord_q + COORD_W'(1);
				end else begin
					coord_q <= coord_q - COORD_W'(1);
				end
			end
		end

		assign pos[i*COORD_W +: COORD_W] = coord_q;
	end

endmodule
`default_nettype wire

// ===== rtl/lwsa_cell.sv =====
// one cell of the history chain: holds an earlier position and compares it
`default_nettype none
module lwsa_cell #(
	parameter int MAX_DIM = lwsa_pkg::MAX_DIM_DEF,
	parameter bit HEAD    = 1'b0
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire lwsa_pkg::lwsa_ctl_t                 ctl,
	input  wire logic [MAX_DIM*lwsa_pkg::COORD_W-1:0] cur_pos,
	input  wire logic [MAX_DIM*lwsa_pkg::COORD_W-1:0] prev_pos,
	input  wire logic                                prev_valid,
	output logic [MAX_DIM*lwsa_pkg::COORD_W-1:0]     pos,
	output logic                                     valid,
	output logic                                     hit
);
	import lwsa_pkg::*;

	logic [MAX_DIM*COORD_W-1:0] pos_q;
	logic                       valid_q;

	// occupancy: after a restart only the head cell holds a row (the origin)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= HEAD;
		end else if (ctl.restart) begin
			valid_q <= HEAD;
		end else if (ctl.shift) begin
			valid_q <= prev_valid;
		end
	end

	// stored position; the head must read as the origin right after reset
	if (HEAD) begin : g_head
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				pos_q <= '0;
			end else if (ctl.restart) begin
				pos_q <= '0;
			end else if (ctl.shift) begin
				pos_q <= prev_pos;
			end
		end
	end else begin : g_body
		always_ff @(posedge clk) begin
			if (ctl.shift) begin
				pos_q <= prev_pos;
			end
		end
	end

	// match against the newest position
	assign hit   = valid_q && (pos_q == cur_pos);
	assign pos   = pos_q;
	assign valid = valid_q;

endmodule
`default_nettype wire

// ===== rtl/lattice_walk_self_avoid_check_unit.sv =====
// top level of the lattice walk self-avoid checker: sequencer, registers, cell chain
//
// Each request on the direction channel (dir_valid / dir_stall) is one step of a
// walk that starts at the origin. Every request gives exactly one result on the
// result channel (res_valid / res_stall): the step count so far, whether the walk
// just finished, whether no position has repeated yet, and whether the direction
// was rejected. Two registers on the APB port set the walk length and the number
// of axes; write them only while no request is in flight.
// One request is in flight at a time: the block takes no new request until the
// current one finishes. A valid step first updates the position register; then
// the new position is compared against the chain of history cells and shifted
// in, unless it ends the walk. The result register frees the chain, but a
// stalled result with a request in flight behind it holds dir_stall high.
// Reset puts the walk at the origin with no steps taken and the registers at
// their defaults; no clearing pass is needed. After the last step of a walk the
// block returns to the origin on its own.
`default_nettype none
module lattice_walk_self_avoid_check_unit #(
	parameter int MAX_LENGTH = lwsa_pkg::MAX_LENGTH_DEF,
	parameter int MAX_DIM    = lwsa_pkg::MAX_DIM_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// step requests
	input  wire logic                        dir_valid,
	output logic                             dir_stall,
	input  wire logic [8:0]                  direction,
	// results
	output logic                             res_valid,
	input  wire logic                        res_stall,
	output logic [5:0]                       steps_taken,
	output logic                             walk_done,
	output logic                             self_avoiding,
	output logic                             bad_direction,
	// configuration
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [lwsa_pkg::ADDR_W-1:0] paddr,
	input  wire logic [lwsa_pkg::DATA_W-1:0] pwdata,
	output logic [lwsa_pkg::DATA_W-1:0]      prdata,
	output logic                             pready
);
	import lwsa_pkg::*;

	localparam int CNT_W = (MAX_LENGTH > 2) ? $clog2(MAX_LENGTH) : 1;
	localparam int POS_W = MAX_DIM * COORD_W;

	logic [6:0]       walk_length_q;
	logic [7:0]       dimensions_q;
	logic             busy_q;
	logic             bad_s1;
	logic [CNT_W-1:0] cnt_q;
	logic             repeat_q;
	logic             res_valid_q;
	logic [5:0]       steps_q;
	logic             done_q;
	logic             avoid_q;
	logic             bad_q;

	logic             accept;
	logic             finish;
	logic             done_w;
	logic             bad_w;
	logic             hit_any;
	logic [8:0]       dims_eff;
	logic [9:0]       len_eff;
	logic [9:0]       cnt_inc;
	logic [8:0]       dir_m1;
	lwsa_ctl_t        ctl;
	logic [POS_W-1:0] cur_pos;

	logic [POS_W-1:0]      chain_pos [MAX_LENGTH];
	logic [MAX_LENGTH-1:0] chain_valid;
	logic [MAX_LENGTH-1:0] hits;

	// configuration port, decoded by word
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_length_q <= WALK_LENGTH_RST;
			dimensions_q  <= DIMENSIONS_RST;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_WALK_LENGTH: walk_length_q <= pwdata[6:0];
				REG_DIMENSIONS:  dimensions_q  <= pwdata[7:0];
				default:         ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_WALK_LENGTH: prdata = {25'd0, walk_length_q};
			REG_DIMENSIONS:  prdata = {24'd0, dimensions_q};
			default:         prdata = '0;
		endcase
	end

	// effective register values, clamped into range
	always_comb begin
		if (dimensions_q == 8'd0) begin
			dims_eff = 9'd1;
		end else if ({1'b0, dimensions_q} > 9'(MAX_DIM)) begin
			dims_eff = 9'(MAX_DIM);
		end else begin
			dims_eff = {1'b0, dimensions_q};
		end
		if (walk_length_q < 7'd2) begin
			len_eff = 10'd2;
		end else if ({3'd0, walk_length_q} > 10'(MAX_LENGTH)) begin
			len_eff = 10'(MAX_LENGTH);
		end else begin
			len_eff = {3'd0, walk_length_q};
		end
	end

	// direction decode at accept
	assign dir_m1 = direction - 9'd1;
	assign bad_w  = (direction == 9'd0) || ({1'b0, direction} > {dims_eff, 1'b0});

	// handshake and sequencing
	assign dir_stall = busy_q;
	assign accept    = dir_valid && !busy_q;
	assign finish    = busy_q && (!res_valid_q || !res_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (accept) begin
			busy_q <= 1'b1;
		end else if (finish) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bad_s1 <= bad_w;
		end
	end

	// position register, stepped at accept
	lwsa_pos #(
		.MAX_DIM(MAX_DIM)
	) u_pos (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.step   (accept && !bad_w),
		.axis   (dir_m1[8:1]),
		.up     (direction[0]),
		.pos    (cur_pos)
	);

	// history chain, newest row in the head cell
	for (genvar k = 0; k < MAX_LENGTH; k++) begin : g_cell
		if (k == 0) begin : g_first
			lwsa_cell #(
				.MAX_DIM(MAX_DIM),
				.HEAD   (1'b1)
			) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctl        (ctl),
				.cur_pos    (cur_pos),
				.prev_pos   (cur_pos),
				.prev_valid (1'b1),
				.pos        (chain_pos[k]),
				.valid      (chain_valid[k]),
				.hit        (hits[k])
			);
		end else begin : g_next
			lwsa_cell #(
				.MAX_DIM(MAX_DIM),
				.HEAD   (1'b0)
			) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctl        (ctl),
				.cur_pos    (cur_pos),
				.prev_pos   (chain_pos[k-1]),
				.prev_valid (chain_valid[k-1]),
				.pos        (chain_pos[k]),
				.valid      (chain_valid[k]),
				.hit        (hits[k])
			);
		end
	end

	assign hit_any = |hits;

	// walk bookkeeping at the compare cycle
	assign cnt_inc     = 10'(cnt_q) + 10'd1;
	assign done_w      = (cnt_inc >= (len_eff - 10'd1));
	assign ctl.shift   = finish && !bad_s1 && !done_w;
	assign ctl.restart = finish && !bad_s1 && done_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			repeat_q <= 1'b0;
		end else if (ctl.restart) begin
			cnt_q    <= '0;
			repeat_q <= 1'b0;
		end else if (ctl.shift) begin
			cnt_q    <= CNT_W'(cnt_inc);
			repeat_q <= repeat_q || hit_any;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (finish) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			if (bad_s1) begin
				steps_q <= 6'(cnt_q);
				done_q  <= 1'b0;
				avoid_q <= !repeat_q;
				bad_q   <= 1'b1;
			end else begin
				steps_q <= 6'(cnt_inc);
				done_q  <= done_w;
				avoid_q <= !(repeat_q || hit_any);
				bad_q   <= 1'b0;
			end
		end
	end

	assign res_valid     = res_valid_q;
	assign steps_taken   = steps_q;
	assign walk_done     = done_q;
	assign self_avoiding = avoid_q;
	assign bad_direction = bad_q;

	// a taken request is always being worked on in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy_q)
		else $error("request taken but sequencer not busy");

	// chain occupancy tracks the step count of the walk
	a_chain_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(chain_valid) == (32'(cnt_q) + 32'd1))
		else $error("history chain fill does not match step count");

	// a new result only comes out of a compare cycle
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(busy_q))
		else $error("result raised without a request in flight");

	// a rejected step never finishes a walk
	a_bad_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && bad_q |-> !done_q)
		else $error("rejected step reported as walk end");

endmodule
`default_nettype wire
